// ===== rtl/vertex_axis_rotation_assert.svh =====
// Assertion macros shared by the vertex rotation block.
`ifndef VERTEX_AXIS_ROTATION_ASSERT_SVH
`define VERTEX_AXIS_ROTATION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define VR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex rotation assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define VR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex rotation assertion failed");

`endif

// ===== rtl/vr_pkg.sv =====
// Package with types, constants and the CORDIC angle table of the vertex rotation block.
`timescale 1ns / 1ps

package vr_pkg;

    localparam int CORDIC_ITERS = 20;
    localparam int DW = 32;     // coordinate width
    localparam int AW = 18;     // configured angle width
    localparam int RW = 19;     // reduced angle width
    localparam int CW = 33;     // CORDIC x and y width, Q30
    localparam int ZW = 26;     // CORDIC residual angle width, degrees in Q16

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [RW-1:0] FULL_TURN       = 19'sd92160;
    localparam logic signed [RW-1:0] HALF_TURN       = 19'sd46080;
    localparam logic signed [RW-1:0] QUARTER_TURN    = 19'sd23040;

    // atan(2^-i) in degrees, Q16.
    localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_ITERS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117305,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
        26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
        26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
    };

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z,
        AXIS_NONE
    } vr_axis_t;

    typedef enum logic {
        REG_AXIS,
        REG_ANGLE
    } vr_reg_index_t;

    typedef struct packed {
        logic signed [DW-1:0] in_x;
        logic signed [DW-1:0] in_y;
        logic signed [DW-1:0] in_z;
    } vr_in_t;

    typedef struct packed {
        logic signed [DW-1:0] out_x;
        logic signed [DW-1:0] out_y;
        logic signed [DW-1:0] out_z;
    } vr_out_t;

    // What one CORDIC cell hands to the next.
    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
        vr_axis_t             axis;
        vr_in_t               vertex;
    } vr_cell_t;

endpackage

// ===== rtl/vr_front.sv =====
// Entry stage: reduces the angle to a quarter turn and seeds the CORDIC chain.
`timescale 1ns / 1ps

module vr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  vr_pkg::vr_in_t                    vertex,
    input  vr_pkg::vr_axis_t                  axis,
    input  logic signed [vr_pkg::AW-1:0]      angle,
    output vr_pkg::vr_cell_t                  cell_out
);
    import vr_pkg::*;

    logic             valid_reg;
    vr_cell_t         data_reg;
    vr_cell_t         data_next;
    logic signed [RW-1:0] ang_ext;
    logic signed [RW-1:0] ang_half;
    logic signed [RW-1:0] ang_quarter;
    logic             neg;

    always_comb
    begin
        ang_ext = RW'(angle);
        // Bring the angle into [-180, 180) degrees.
        if (ang_ext >= HALF_TURN)
        begin
            ang_half = ang_ext - FULL_TURN;
        end
        else if (ang_ext < -HALF_TURN)
        begin
            ang_half = ang_ext + FULL_TURN;
        end
        else
        begin
            ang_half = ang_ext;
        end
        // Fold beyond a quarter turn and negate the sine and cosine later.
        if (ang_half > QUARTER_TURN)
        begin
            ang_quarter = ang_half - HALF_TURN;
            neg         = 1'b1;
        end
        else if (ang_half < -QUARTER_TURN)
        begin
            ang_quarter = ang_half + HALF_TURN;
            neg         = 1'b1;
        end
        else
        begin
            ang_quarter = ang_half;
            neg         = 1'b0;
        end
        data_next.valid  = accept;
        data_next.x      = CORDIC_GAIN_Q30;
        data_next.y      = '0;
        data_next.z      = {ZW'(ang_quarter) << 8};
        data_next.neg    = neg;
        data_next.axis   = axis;
        data_next.vertex = vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

// ===== rtl/vr_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation, registered toward the next cell.
`timescale 1ns / 1ps

module vr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  vr_pkg::vr_cell_t cell_in,
    output vr_pkg::vr_cell_t cell_out
);
    import vr_pkg::*;

    logic                 valid_reg;
    vr_cell_t             data_reg;
    vr_cell_t             data_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx        = cell_in.y >>> STAGE;
        dy        = cell_in.x >>> STAGE;
        data_next = cell_in;
        if (cell_in.z >= 0)
        begin
            data_next.x = cell_in.x - dx;
            data_next.y = cell_in.y + dy;
            data_next.z = cell_in.z - ATAN_Q16[STAGE];
        end
        else
        begin
            data_next.x = cell_in.x + dx;
            data_next.y = cell_in.y - dy;
            data_next.z = cell_in.z + ATAN_Q16[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

// ===== rtl/vr_rotate.sv =====
// Rotation back end: four products, then round, saturate and place the coordinates.
`timescale 1ns / 1ps

module vr_rotate (
    input  logic             clk,
    input  logic             rst_n,
    input  vr_pkg::vr_cell_t cell_in,
    output logic             done,
    output vr_pkg::vr_out_t  result
);
    import vr_pkg::*;

    localparam int PW = CW + DW;
    localparam int SW = PW + 1;

    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    logic signed [DW-1:0] va;
    logic signed [DW-1:0] vb;

    logic                 valid1_reg;
    vr_axis_t             axis1_reg;
    vr_in_t               vertex1_reg;
    logic signed [PW-1:0] pac_reg;
    logic signed [PW-1:0] pbs_reg;
    logic signed [PW-1:0] pbc_reg;
    logic signed [PW-1:0] pas_reg;

    logic signed [SW-1:0] sum_a;
    logic signed [SW-1:0] sum_b;
    logic signed [DW-1:0] ra;
    logic signed [DW-1:0] rb;
    vr_out_t              result_next;
    logic                 done_reg;
    vr_out_t              result_reg;

    function automatic logic signed [DW-1:0] round_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0]    t;
        logic signed [SW-31:0]   r;
        t = v + SW'(33'sh20000000);
        r = t[SW-1:30];
        if (r[SW-31:DW-1] == '0 || r[SW-31:DW-1] == '1)
        begin
            round_sat = r[DW-1:0];
        end
        else if (r[SW-31])
        begin
            round_sat = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            round_sat = {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    always_comb
    begin
        c = cell_in.neg ? -cell_in.x : cell_in.x;
        s = cell_in.neg ? -cell_in.y : cell_in.y;
        case (cell_in.axis)
            AXIS_X:
            begin
                va = cell_in.vertex.in_y;
                vb = cell_in.vertex.in_z;
            end
            AXIS_Y:
            begin
                va = cell_in.vertex.in_x;
                vb = cell_in.vertex.in_z;
            end
            default:
            begin
                va = cell_in.vertex.in_x;
                vb = cell_in.vertex.in_y;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= cell_in.valid;
            done_reg   <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        axis1_reg   <= cell_in.axis;
        vertex1_reg <= cell_in.vertex;
        pac_reg     <= c * va;
        pbs_reg     <= s * vb;
        pbc_reg     <= c * vb;
        pas_reg     <= s * va;
        result_reg  <= result_next;
    end

    always_comb
    begin
        sum_a = SW'(pac_reg) - SW'(pbs_reg);
        sum_b = SW'(pbc_reg) + SW'(pas_reg);
        ra    = round_sat(sum_a);
        rb    = round_sat(sum_b);
        result_next.out_x = vertex1_reg.in_x;
        result_next.out_y = vertex1_reg.in_y;
        result_next.out_z = vertex1_reg.in_z;
        case (axis1_reg)
            AXIS_X:
            begin
                result_next.out_y = ra;
                result_next.out_z = rb;
            end
            AXIS_Y:
            begin
                result_next.out_x = ra;
                result_next.out_z = rb;
            end
            AXIS_Z:
            begin
                result_next.out_x = ra;
                result_next.out_y = rb;
            end
            default:
            begin
                result_next.out_x = vertex1_reg.in_x;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/vertex_axis_rotation.sv =====
// Top level of the vertex rotation block: configuration registers, CORDIC chain, back end.
`timescale 1ns / 1ps
// Usage.
// The block rotates one vertex (Q15.16 x, y, z) about the configured principal axis by
// the configured angle in degrees times 256. A transfer on the input side happens at a
// rising edge with start high and busy low; busy is high only in the first cycle after
// reset and low from then on, so one vertex can be transferred in every cycle.
// Each vertex passes through a chain of registered steps after its transfer: angle reduction,
// twenty CORDIC cells that each perform one micro-rotation per cycle, the four 33x32
// products, and rounding, saturation and the output register.
// The chain of CORDIC cells advances every cycle, so throughput is one vertex per cycle.
// The result appears on result for exactly one cycle with done high; the receiver
// cannot hold it off, so no stall exists on the output side.
// Configuration is written through cfg_we, cfg_index and cfg_data while no vertex is in
// flight; index 0 is the rotation axis, index 1 the angle.
// Reset clears the axis and the angle to zero and empties the pipeline.
`include "vertex_axis_rotation_assert.svh"

module vertex_axis_rotation (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  vr_pkg::vr_in_t          vertex,
    output logic                    done,
    output vr_pkg::vr_out_t         result,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [vr_pkg::AW-1:0]   cfg_data
);
    import vr_pkg::*;

    localparam int LATENCY = CORDIC_ITERS + 3;

    logic                 busy_reg;
    vr_axis_t             axis_reg;
    logic signed [AW-1:0] angle_reg;
    logic                 accept;
    vr_cell_t             chain [CORDIC_ITERS+1];

    // Busy only while the block comes out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Config registers; the user must write only while the pipeline is empty; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg  <= AXIS_X;
            angle_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_AXIS)
            begin
                axis_reg <= vr_axis_t'(cfg_data[1:0]);
            end
            else
            begin
                angle_reg <= cfg_data;
            end
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    vr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .vertex   (vertex),
        .axis     (axis_reg),
        .angle    (angle_reg),
        .cell_out (chain[0])
    );

    // The CORDIC chain: cell i applies the micro-rotation by atan(2^-i).
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_cell
        vr_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    vr_rotate u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_in (chain[CORDIC_ITERS]),
        .done    (done),
        .result  (result)
    );

    // Every transfer in yields exactly one result a fixed latency later, and no other.
    `VR_ASSERT_IMPLY(a_result_follows, accept, ##LATENCY done)
    `VR_ASSERT_IMPLY(a_result_has_cause, done, $past(accept, LATENCY))
    // Once released from reset the block never turns busy again.
    `VR_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

endmodule

// ===== tb/tb_vertex_axis_rotation.sv =====
// Self-checking testbench for vertex_axis_rotation with a built-in rotation predictor.
`timescale 1ns / 1ps

module tb_vertex_axis_rotation;

    import vr_pkg::*;

    // Timing of the run. The drain at the end keeps waiting after the last owed result
    // has come back, before the verdict.
    localparam int PIPE_LATENCY    = 23;
    localparam int DRAIN_CYCLES    = 2 * PIPE_LATENCY + 10;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_VERTICES = 1250;
    localparam int REPORT_LIMIT    = 10;

    // Angle arithmetic in degrees times 256, and the CORDIC start value (gain in Q30).
    localparam longint TURN_Q8    = 92160;
    localparam longint HALF_Q8    = 46080;
    localparam longint QUARTER_Q8 = 23040;
    localparam longint GAIN_Q30   = 652032874;
    localparam int     MICRO_ROTS = 20;

    // atan(2^-i) in degrees, Q16, one entry per micro-rotation.
    localparam longint ATAN_DEG_Q16 [MICRO_ROTS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    localparam logic signed [DW-1:0] C_MAX = 32'sh7fffffff;
    localparam logic signed [DW-1:0] C_MIN = 32'sh80000000;
    localparam logic signed [DW-1:0] C_ONE = 32'sh00010000;    // 1.0 in Q15.16

    // Every input of the block is known from time zero; reset is held low at start.
    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            start     = 1'b0;
    logic            busy;
    vr_in_t          vertex    = '0;
    logic            done;
    vr_out_t         result;
    logic            cfg_we    = 1'b0;
    logic            cfg_index = 1'b0;
    logic [AW-1:0]   cfg_data  = '0;

    // Our own copy of the two configuration registers, updated when we write them.
    vr_axis_t              axis_setting  = AXIS_X;
    logic signed [AW-1:0]  angle_setting = '0;

    // Rotated vertices still owed by the block, oldest first.
    vr_out_t pending_rotations [$];

    int  cycle_count    = 0;
    int  mismatches     = 0;
    int  results_seen   = 0;
    int  vertices_sent  = 0;
    int  config_writes  = 0;
    int  clipped_coords = 0;
    int  axis_hits [4]  = '{0, 0, 0, 0};
    bit  steady_flow    = 1'b0;

    vertex_axis_rotation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vertex    (vertex),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rounds a Q30-scaled product back to the coordinate format (round half up) and
    // clamps it to 32 bits, counting how often the clamp is hit.
    function automatic logic signed [DW-1:0] round_sat(input longint prod);
        longint q;
        q = (prod + (64'sd1 <<< 29)) >>> 30;
        if (q > 64'sd2147483647)
        begin
            clipped_coords++;
            return C_MAX;
        end
        if (q < -64'sd2147483648)
        begin
            clipped_coords++;
            return C_MIN;
        end
        return q[DW-1:0];
    endfunction

    // Predicts the rotated vertex for one input under the given axis and angle.
    // The angle is folded into [-90, 90] degrees, with a sign flip on both sine and
    // cosine when it had to be moved by half a turn, then run through the CORDIC.
    function automatic vr_out_t rotate_vertex(input vr_in_t v, input vr_axis_t ax,
                                              input logic signed [AW-1:0] ang);
        longint               crd [3];
        logic signed [DW-1:0] outc [3];
        longint               r;
        longint               cx;
        longint               sy;
        longint               rz;
        longint               dx;
        longint               dy;
        bit                   flip;
        int                   a;
        int                   b;
        vr_out_t              res;
        crd[0]  = v.in_x;
        crd[1]  = v.in_y;
        crd[2]  = v.in_z;
        outc[0] = v.in_x;
        outc[1] = v.in_y;
        outc[2] = v.in_z;
        flip    = 1'b0;
        if (ax != AXIS_NONE)
        begin
            case (ax)
                AXIS_X:  begin a = 1; b = 2; end
                AXIS_Y:  begin a = 0; b = 2; end
                default: begin a = 0; b = 1; end
            endcase
            r = longint'(ang) % TURN_Q8;
            if (r < 0)
                r += TURN_Q8;
            if (r >= HALF_Q8)
                r -= TURN_Q8;
            if (r > QUARTER_Q8)
            begin
                r -= HALF_Q8;
                flip = 1'b1;
            end
            else if (r < -QUARTER_Q8)
            begin
                r += HALF_Q8;
                flip = 1'b1;
            end
            cx = GAIN_Q30;
            sy = 0;
            rz = r * 256;
            for (int i = 0; i < MICRO_ROTS; i++)
            begin
                dx = sy >>> i;
                dy = cx >>> i;
                if (rz >= 0)
                begin
                    cx -= dx;
                    sy += dy;
                    rz -= ATAN_DEG_Q16[i];
                end
                else
                begin
                    cx += dx;
                    sy -= dy;
                    rz += ATAN_DEG_Q16[i];
                end
            end
            if (flip)
            begin
                cx = -cx;
                sy = -sy;
            end
            outc[a] = round_sat(cx * crd[a] - sy * crd[b]);
            outc[b] = round_sat(cx * crd[b] + sy * crd[a]);
        end
        res.out_x = outc[0];
        res.out_y = outc[1];
        res.out_z = outc[2];
        return res;
    endfunction

    function automatic vr_in_t make_vertex(input logic signed [DW-1:0] x,
                                           input logic signed [DW-1:0] y,
                                           input logic signed [DW-1:0] z);
        vr_in_t v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        return v;
    endfunction

    // Random coordinates: mostly full 32-bit values, some small ones near the origin
    // and some at the extremes, so both quiet and saturating cases keep turning up.
    function automatic vr_in_t random_vertex();
        logic signed [DW-1:0] c [3];
        int                   roll;
        for (int k = 0; k < 3; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                c[k] = $urandom;
            else if (roll < 85)
                c[k] = $urandom_range(0, 2 * 1048576) - 1048576;
            else
            begin
                case ($urandom_range(0, 4))
                    0:       c[k] = C_MAX;
                    1:       c[k] = C_MIN;
                    2:       c[k] = '0;
                    3:       c[k] = -1;
                    default: c[k] = 1;
                endcase
            end
        end
        return make_vertex(c[0], c[1], c[2]);
    endfunction

    // Gap after a transfer: mostly none, sometimes a few cycles, rarely a long one.
    // Steady phases send back to back to keep the pipeline full.
    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offers one vertex and holds it until the block takes it. The expected result
    // is queued at the transfer edge with the settings in force. During a gap start
    // drops and the vertex bus carries junk that the block has to ignore.
    task automatic send_vertex(input vr_in_t v);
        int gap;
        start  <= 1'b1;
        vertex <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rotations.push_back(rotate_vertex(v, axis_setting, angle_setting));
        vertices_sent++;
        axis_hits[axis_setting]++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start  <= 1'b0;
            vertex <= random_vertex();
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Writes the axis and/or the angle register. The block must be idle, so start
    // drops and we wait until every owed result has come back; since each vertex
    // gives exactly one result, an empty queue means an empty pipeline. Back-to-back
    // writes keep cfg_we high across both cycles.
    task automatic configure(input bit do_axis, input vr_axis_t ax,
                             input bit do_angle, input logic signed [AW-1:0] ang);
        start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
        if (do_axis)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_AXIS;
            cfg_data  <= AW'(ax);
            @(posedge clk);
            axis_setting = ax;
            config_writes++;
        end
        if (do_angle)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ANGLE;
            cfg_data  <= ang;
            @(posedge clk);
            angle_setting = ang;
            config_writes++;
        end
        cfg_we <= 1'b0;
    endtask

    // After reset both registers are zero: rotation about x by zero degrees, which
    // still goes through the CORDIC and the rounding.
    task automatic test_reset_state();
        send_vertex(make_vertex(C_MAX, C_MIN, C_ONE));
        send_vertex(make_vertex(C_MIN, C_MAX, -1));
    endtask

    // One setting per principal axis, with vertices that hit saturation.
    task automatic test_rotation_axes();
        configure(1'b1, AXIS_Z, 1'b1, 18'sd11520);     // 45 degrees
        send_vertex(make_vertex(C_MAX, C_MAX, C_MIN));
        send_vertex(make_vertex(C_MIN, C_MAX, 0));
        send_vertex(make_vertex(C_ONE, 0, C_MAX));
        send_vertex(make_vertex(0, -C_ONE, 1));
        configure(1'b1, AXIS_Y, 1'b1, -18'sd34560);    // -135 degrees
        send_vertex(make_vertex(C_MIN, C_MAX, C_MIN));
        send_vertex(make_vertex(C_ONE, 7, -C_ONE));
        send_vertex(make_vertex(-1, -1, -1));
        configure(1'b1, AXIS_X, 1'b1, 18'sd23040);     // exactly 90 degrees
        send_vertex(make_vertex(C_MAX, C_MAX, C_MIN));
        send_vertex(make_vertex(5, C_ONE, 3 * C_ONE));
    endtask

    // Axis code 3 leaves all three coordinates as they are, whatever the angle.
    task automatic test_pass_through();
        configure(1'b1, AXIS_NONE, 1'b1, 18'sd7680);
        send_vertex(make_vertex(C_MAX, C_MIN, C_MAX));
        send_vertex(make_vertex(C_MIN, 0, -1));
        send_vertex(make_vertex(32'sh5a5a5a5a, 32'sha5a5a5a5, 1));
    endtask

    // Angles at full and half turns, just past a quarter turn, and beyond a full
    // turn up to the extremes of the 18-bit register, which wrap modulo 360.
    task automatic test_angle_wrap();
        configure(1'b1, AXIS_Z, 1'b1, 18'sd92160);
        send_vertex(make_vertex(C_MAX, C_MIN, C_ONE));
        send_vertex(make_vertex(C_ONE, -C_ONE, 0));
        configure(1'b0, AXIS_Z, 1'b1, -18'sd92160);
        send_vertex(make_vertex(C_MIN, C_MAX, 2));
        configure(1'b1, AXIS_Y, 1'b1, 18'sd131071);
        send_vertex(make_vertex(C_MAX, 9, C_MAX));
        send_vertex(make_vertex(-C_ONE, C_MIN, C_ONE));
        configure(1'b0, AXIS_Y, 1'b1, -18'sd131072);
        send_vertex(make_vertex(C_MIN, C_MAX, C_MIN));
        send_vertex(make_vertex(3 * C_ONE, -5, -C_ONE));
        configure(1'b1, AXIS_X, 1'b1, -18'sd46080);    // -180 degrees
        send_vertex(make_vertex(1, C_MAX, C_MIN));
        configure(1'b0, AXIS_X, 1'b1, 18'sd23041);     // one step past 90 degrees
        send_vertex(make_vertex(0, C_MIN, C_MAX));
    endtask

    // Random phases: each picks a setting (now and then only one register is
    // rewritten), then streams a random number of random vertices. Every fourth
    // phase sends back to back with no idle cycles.
    task automatic test_random_stream();
        int                   sent;
        int                   phase;
        int                   burst;
        int                   roll;
        vr_axis_t             ax;
        logic signed [AW-1:0] ang;
        int                   ang_int;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_VERTICES)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                ax = vr_axis_t'($urandom_range(0, 2));
            else
                ax = AXIS_NONE;
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                ang_int = int'($urandom_range(0, 2 * 92160)) - 92160;
                ang     = ang_int[AW-1:0];
            end
            else if (roll < 85)
                ang = AW'($urandom);
            else
            begin
                case ($urandom_range(0, 6))
                    0:       ang = '0;
                    1:       ang = 18'sd23040;
                    2:       ang = -18'sd23040;
                    3:       ang = 18'sd46080;
                    4:       ang = -18'sd46080;
                    5:       ang = 18'sd92160;
                    default: ang = -18'sd92160;
                endcase
            end
            roll = $urandom_range(0, 9);
            configure(roll != 0, ax, roll != 1, ang);
            steady_flow = (phase % 4 == 3);
            burst = $urandom_range(40, 140);
            repeat (burst)
                send_vertex(random_vertex());
            sent  += burst;
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    // Result checker. done and result are sampled at the rising edge that ends the
    // result cycle; each result is matched field by field against the oldest
    // expected rotation. A result with nothing owed is a failure of its own.
    always @(posedge clk)
    begin
        vr_out_t              want;
        logic signed [DW-1:0] got_f [3];
        logic signed [DW-1:0] want_f [3];
        string                field_name [3];
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_rotations.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no vertex outstanding: x=%0d y=%0d z=%0d",
                             $realtime, result.out_x, result.out_y, result.out_z);
            end
            else
            begin
                want          = pending_rotations.pop_front();
                got_f[0]      = result.out_x;
                got_f[1]      = result.out_y;
                got_f[2]      = result.out_z;
                want_f[0]     = want.out_x;
                want_f[1]     = want.out_y;
                want_f[2]     = want.out_z;
                field_name[0] = "out_x";
                field_name[1] = "out_y";
                field_name[2] = "out_z";
                for (int k = 0; k < 3; k++)
                begin
                    if (got_f[k] !== want_f[k])
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: %s expected %0d (0x%h), got %0d (0x%h)",
                                     $realtime, field_name[k], want_f[k], want_f[k],
                                     got_f[k], got_f[k]);
                    end
                end
            end
        end
    end

    // Watchdog: a generous bound on the whole run, far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_rotations.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Main sequence: reset once, then the directed tests, then the random stream,
    // then a drain and the verdict.
    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_rotation_axes();
        test_pass_through();
        test_angle_wrap();
        test_random_stream();

        // Stop offering vertices, collect what is owed, then keep watching for a
        // while so that any surplus result would still be caught.
        start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d vertices and %0d results over %0d register writes.",
                 vertices_sent, results_seen, config_writes);
        $display("Per axis x/y/z/none: %0d/%0d/%0d/%0d; clamped coordinates: %0d.",
                 axis_hits[0], axis_hits[1], axis_hits[2], axis_hits[3], clipped_coords);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/vr_pkg.sv
rtl/vr_front.sv
rtl/vr_cordic_cell.sv
rtl/vr_rotate.sv
rtl/vertex_axis_rotation.sv
tb/tb_vertex_axis_rotation.sv
